FILE: src/spo2rw_pkg.sv
package spo2rw_pkg;

    localparam int SAMPLE_W = 18;
    localparam int SAT_W = 15;
    localparam int WINDOW_LEN_DEF = 50;
    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 18'd5000;
    localparam logic [SAT_W-1:0] SAT_MAX = 15'd25600;
    localparam int OFFSET_FX = 28160;
    localparam int SLOPE_FX = 6400;

    // quotient bits: q < 2*28160 < 2^16, computed one bit per cycle
    localparam int QUO_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input transaction
        logic store;       // write pair into windows
        logic scan_start;  // clear accumulators, start read
        logic mul_step;    // one multiply stage
        logic div_start;   // load divider
        logic div_step;    // one quotient bit
        logic finish;      // form result register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic contact;
        logic full;
        logic scan_done;
        logic mul_done;
        logic div_done;
    } dp_sts_t;

endpackage

FILE: src/spo2_ratio_window_estimator_unit.sv
// SpO2 ratio-of-ratios estimator. Each s_ transaction carries one infrared
// and one red 18-bit sample; each gives exactly one m_ transaction. Pairs
// with the ir sample below cfg threshold (reset 5000) report no contact and
// are not stored. Stored pairs go into two WINDOW_LEN-entry circular
// windows; once the window has filled, every stored pair rescans both
// windows and outputs SpO2 = 110 - 25*R, clamped 0..100, times 256 (no
// estimate if a window sum or the ir swing is zero). One item at a time:
// an item that is not scored (no contact, or the window still filling)
// goes from the scan state straight to output; a full-window item passes
// the window write, a window scan over one memory read port, two multiply
// stages, a bit-serial divider and output. A stalled result holds the
// next item in its output state. No clearing pass is needed.
module spo2_ratio_window_estimator_unit #(
    parameter int WINDOW_LEN = spo2rw_pkg::WINDOW_LEN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spo2rw_pkg::SAMPLE_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [spo2rw_pkg::SAMPLE_W-1:0]   s_ir_sample,
    input  logic [spo2rw_pkg::SAMPLE_W-1:0]   s_red_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_contact,
    output logic                              m_estimate_valid,
    output logic [spo2rw_pkg::SAT_W-1:0]      m_saturation
);
    import spo2rw_pkg::*;

    logic [SAMPLE_W-1:0] thresh_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    spo2rw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    spo2rw_datapath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .threshold      (thresh_reg),
        .ir_in          (s_ir_sample),
        .red_in         (s_red_sample),
        .contact        (m_contact),
        .estimate_valid (m_estimate_valid),
        .saturation     (m_saturation)
    );

endmodule

FILE: src/spo2rw_datapath.sv
module spo2rw_datapath #(
    parameter int WINDOW_LEN = spo2rw_pkg::WINDOW_LEN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  spo2rw_pkg::dp_cmd_t               cmd,
    output spo2rw_pkg::dp_sts_t               sts,
    input  logic [spo2rw_pkg::SAMPLE_W-1:0]   threshold,
    input  logic [spo2rw_pkg::SAMPLE_W-1:0]   ir_in,
    input  logic [spo2rw_pkg::SAMPLE_W-1:0]   red_in,
    output logic                              contact,
    output logic                              estimate_valid,
    output logic [spo2rw_pkg::SAT_W-1:0]      saturation
);
    import spo2rw_pkg::*;

    localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN + 1);
    localparam int PROD_W = SAMPLE_W + SUM_W;     // ac * sum
    localparam int DEN_W = PROD_W + 15;           // 28160 * den fits in +15
    localparam logic [AW-1:0] LAST = AW'(WINDOW_LEN - 1);

    logic [SAMPLE_W-1:0] ir_mem [WINDOW_LEN];
    logic [SAMPLE_W-1:0] red_mem [WINDOW_LEN];

    logic [SAMPLE_W-1:0] ir_reg, red_reg;
    logic [AW-1:0] wpos_reg, raddr_reg;
    logic full_reg;
    logic [SAMPLE_W-1:0] ir_rd_reg, red_rd_reg;
    logic rd_vld_reg, rd_last_reg, reading_reg, scan_done_reg;
    logic [SAMPLE_W-1:0] ir_min_reg, ir_max_reg, red_min_reg, red_max_reg;
    logic [SUM_W-1:0] ir_sum_reg, red_sum_reg;
    logic [1:0] mul_cnt_reg;
    logic [PROD_W-1:0] num_reg, den_reg;
    logic [DEN_W-1:0] a_reg, b_reg;  // a = slope*num, b = offset*den
    logic ok_reg, zero_reg;
    logic [DEN_W+1:0] rem_reg, dvs_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [$clog2(QUO_W+1)-1:0] bit_cnt_reg;
    logic [SAMPLE_W-1:0] ir_ac, red_ac;

    assign ir_ac = ir_max_reg - ir_min_reg;
    assign red_ac = red_max_reg - red_min_reg;
    assign sts.contact = (ir_reg >= threshold);
    assign sts.full = full_reg;
    assign sts.scan_done = scan_done_reg;
    assign sts.mul_done = (mul_cnt_reg == 2'd2);
    assign sts.div_done = (bit_cnt_reg == '0);

    // window memories, one write and one registered read port each
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            ir_mem[wpos_reg] <= ir_reg;
            red_mem[wpos_reg] <= red_reg;
        end
        ir_rd_reg <= ir_mem[raddr_reg];
        red_rd_reg <= red_mem[raddr_reg];
    end

    // input capture and write pointer
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ir_reg <= ir_in;
            red_reg <= red_in;
        end
        if (!aresetn) begin
            wpos_reg <= '0;
            full_reg <= 1'b0;
        end else if (cmd.store) begin
            if (wpos_reg == LAST) begin
                wpos_reg <= '0;
                full_reg <= 1'b1;
            end else begin
                wpos_reg <= wpos_reg + 1'b1;
            end
        end
    end

    // window scan: min, max, sum; a restart drops reads still in the pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reading_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            scan_done_reg <= 1'b0;
        end else begin
            rd_vld_reg <= reading_reg && !cmd.scan_start;
            scan_done_reg <= rd_vld_reg && rd_last_reg && !cmd.scan_start;
            if (cmd.scan_start) begin
                reading_reg <= 1'b1;
            end else if (reading_reg && raddr_reg == LAST) begin
                reading_reg <= 1'b0;
            end
        end
        rd_last_reg <= (raddr_reg == LAST);
        if (cmd.scan_start) begin
            raddr_reg <= '0;
            ir_min_reg <= '1;
            red_min_reg <= '1;
            ir_max_reg <= '0;
            red_max_reg <= '0;
            ir_sum_reg <= '0;
            red_sum_reg <= '0;
        end else begin
            if (reading_reg && raddr_reg != LAST) begin
                raddr_reg <= raddr_reg + 1'b1;
            end
            if (rd_vld_reg) begin
                if (ir_rd_reg < ir_min_reg) ir_min_reg <= ir_rd_reg;
                if (ir_rd_reg > ir_max_reg) ir_max_reg <= ir_rd_reg;
                if (red_rd_reg < red_min_reg) red_min_reg <= red_rd_reg;
                if (red_rd_reg > red_max_reg) red_max_reg <= red_rd_reg;
                ir_sum_reg <= ir_sum_reg + SUM_W'(ir_rd_reg);
                red_sum_reg <= red_sum_reg + SUM_W'(red_rd_reg);
            end
        end
    end

    // two multiply stages: products, then scaling by constants
    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            mul_cnt_reg <= '0;
        end else if (cmd.mul_step) begin
            if (mul_cnt_reg == 2'd0) begin
                num_reg <= PROD_W'(red_ac) * PROD_W'(ir_sum_reg);
                den_reg <= PROD_W'(red_sum_reg) * PROD_W'(ir_ac);
                ok_reg <= (ir_sum_reg != '0) && (red_sum_reg != '0) && (ir_ac != '0);
            end else begin
                a_reg <= DEN_W'(num_reg) * DEN_W'(SLOPE_FX);
                b_reg <= DEN_W'(den_reg) * DEN_W'(OFFSET_FX);
            end
            mul_cnt_reg <= mul_cnt_reg + 2'd1;
        end
    end

    // restoring divider: q = (2d + den) / (2 den), one bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
        end else if (cmd.div_start) begin
            zero_reg <= (a_reg >= b_reg);
            rem_reg <= {1'b0, b_reg - a_reg, 1'b0} + (DEN_W+2)'(den_reg);
            dvs_reg <= (DEN_W+2)'({den_reg, 1'b0}) << QUO_W;
            quo_reg <= '0;
            bit_cnt_reg <= ($clog2(QUO_W+1))'(QUO_W);
        end else if (cmd.div_step && bit_cnt_reg != '0) begin
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
            dvs_reg <= dvs_reg >> 1;
            if (rem_reg >= (dvs_reg >> 1)) begin
                rem_reg <= rem_reg - (dvs_reg >> 1);
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contact <= 1'b0;
            estimate_valid <= 1'b0;
            saturation <= '0;
        end else if (cmd.finish) begin
            contact <= sts.contact;
            estimate_valid <= 1'b0;
            saturation <= '0;
            if (sts.contact && full_reg && ok_reg) begin
                estimate_valid <= 1'b1;
                if (zero_reg) saturation <= '0;
                else if (quo_reg > QUO_W'(SAT_MAX)) saturation <= SAT_MAX;
                else saturation <= quo_reg[SAT_W-1:0];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_wpos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wpos_reg <= LAST) else $error("write pointer out of range");
    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(full_reg) |-> full_reg) else $error("window full dropped");
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        saturation <= SAT_MAX || !estimate_valid) else $error("saturation above max");
`endif

endmodule

FILE: src/spo2rw_ctrl.sv
module spo2rw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  spo2rw_pkg::dp_sts_t  sts,
    output spo2rw_pkg::dp_cmd_t  cmd
);
    import spo2rw_pkg::*;

    state_t state_reg, state_next;
    logic out_vld_reg, out_vld_next;
    logic finish;
    logic scan_entry_reg, scan_entry;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_vld_reg;

    // store happens on the first cycle after capture, only with contact
    assign scan_entry = scan_entry_reg && sts.contact;

    // next state; the first scan cycle waits for the window write to land
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_SCAN;
            ST_SCAN: begin
                if (!scan_entry_reg) begin
                    if (!sts.contact || !sts.full) state_next = ST_OUT;
                    else if (sts.scan_done) state_next = ST_MUL;
                end
            end
            ST_MUL: if (sts.mul_done) state_next = ST_DIV;
            ST_DIV: if (sts.div_done) state_next = ST_OUT;
            ST_OUT: if (!out_vld_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        finish = 1'b0;
        unique case (state_reg)
            ST_IDLE: cmd.load = s_valid;
            ST_SCAN: ;
            ST_MUL: cmd.mul_step = 1'b1;
            ST_DIV: cmd.div_step = 1'b1;
            ST_OUT: finish = !out_vld_reg || m_ready;
            default: ;
        endcase
        cmd.finish = finish;
        cmd.div_start = (state_reg == ST_MUL) && sts.mul_done;
        // scan starts with the write so it reads the updated window
        cmd.scan_start = scan_entry;
        cmd.store = scan_entry;
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (m_ready) out_vld_next = 1'b0;
        if (finish) out_vld_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_vld_reg <= 1'b0;
            scan_entry_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_vld_reg <= out_vld_next;
            scan_entry_reg <= cmd.load;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("accepted during work");
    a_finish_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> (!out_vld_reg || m_ready)) else $error("result overwritten");
    a_store_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |=> !cmd.store) else $error("double store");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import spo2rw_pkg::*;

    localparam int WLEN = WINDOW_LEN_DEF;
    localparam int N_RANDOM = 1600;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [SAMPLE_W-1:0] SMAX = '1;

    // one result transaction
    typedef struct packed {
        logic             contact;
        logic             estimate_valid;
        logic [SAT_W-1:0] saturation;
    } spo2_result_t;

    // one directed row; check_fixed means the result is typed in
    typedef struct {
        logic [SAMPLE_W-1:0] ir;
        logic [SAMPLE_W-1:0] red;
        bit                  check_fixed;
        spo2_result_t        fixed;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [SAMPLE_W-1:0] cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_ir_sample;
    logic [SAMPLE_W-1:0] s_red_sample;
    logic                m_valid;
    logic                m_ready;
    logic                m_contact;
    logic                m_estimate_valid;
    logic [SAT_W-1:0]    m_saturation;

    spo2_ratio_window_estimator_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_ir_sample      (s_ir_sample),
        .s_red_sample     (s_red_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_contact        (m_contact),
        .m_estimate_valid (m_estimate_valid),
        .m_saturation     (m_saturation)
    );

    // predictor state
    logic [SAMPLE_W-1:0] model_thresh;
    logic [SAMPLE_W-1:0] model_ir_win [WLEN];
    logic [SAMPLE_W-1:0] model_red_win [WLEN];
    int                  model_wpos;
    bit                  model_full;

    spo2_result_t expected_results[$];
    int  errors;
    int  idle_cycles;
    int  n_results;
    int  n_valid_est;
    bit  hold_off;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ratio-of-ratios estimate over the current windows
    function automatic spo2_result_t spo2_from_windows();
        spo2_result_t r;
        logic [SAMPLE_W-1:0] imin, imax, rmin, rmax;
        logic [63:0] isum, rsum, iac, rac, num, den, neg, d, q;
        imin = SMAX; imax = '0; rmin = SMAX; rmax = '0;
        isum = 0; rsum = 0;
        for (int i = 0; i < WLEN; i++) begin
            if (model_ir_win[i] < imin) imin = model_ir_win[i];
            if (model_ir_win[i] > imax) imax = model_ir_win[i];
            if (model_red_win[i] < rmin) rmin = model_red_win[i];
            if (model_red_win[i] > rmax) rmax = model_red_win[i];
            isum += 64'(model_ir_win[i]);
            rsum += 64'(model_red_win[i]);
        end
        iac = 64'(imax - imin);
        rac = 64'(rmax - rmin);
        r = '0;
        r.contact = 1'b1;
        if (isum == 0 || rsum == 0 || iac == 0) return r;
        r.estimate_valid = 1'b1;
        num = rac * isum;
        den = rsum * iac;
        neg = 64'(SLOPE_FX) * num;
        if (neg >= 64'(OFFSET_FX) * den) return r;
        d = 64'(OFFSET_FX) * den - neg;
        q = (64'd2 * d + den) / (64'd2 * den);
        if (q > 64'(SAT_MAX)) q = 64'(SAT_MAX);
        r.saturation = q[SAT_W-1:0];
        return r;
    endfunction

    // advance predictor by one sample pair
    function automatic spo2_result_t spo2_predict(logic [SAMPLE_W-1:0] ir,
                                                  logic [SAMPLE_W-1:0] red);
        spo2_result_t r;
        r = '0;
        if (ir < model_thresh) return r;
        model_ir_win[model_wpos] = ir;
        model_red_win[model_wpos] = red;
        model_wpos++;
        if (model_wpos >= WLEN) begin
            model_wpos = 0;
            model_full = 1'b1;
        end
        r.contact = 1'b1;
        if (model_full) r = spo2_from_windows();
        return r;
    endfunction

    task automatic idle_wait(int n);
        repeat (n) @(posedge aclk);
    endtask

    // send one sample transaction, queue its expectation
    task automatic send_pair(logic [SAMPLE_W-1:0] ir, logic [SAMPLE_W-1:0] red,
                             bit use_gaps, bit check_fixed = 0,
                             spo2_result_t fixed = '0);
        spo2_result_t p;
        int gap;
        gap = 0;
        if (use_gaps) gap = $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            idle_wait(gap);
        end
        s_valid <= 1'b1;
        s_ir_sample <= ir;
        s_red_sample <= red;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = spo2_predict(ir, red);
        if (check_fixed && p != fixed) begin
            $error("table row mismatch: typed %h predictor %h", fixed, p);
            errors++;
        end
        expected_results.push_back(check_fixed ? fixed : p);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        idle_wait(WLEN + 40);
    endtask

    task automatic write_thresh(logic [SAMPLE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        model_thresh = v;
    endtask

    // fill the window with a pulsing pair stream
    task automatic send_pulse_run(int n, bit use_gaps);
        logic [SAMPLE_W-1:0] ibase, rbase, ir, red;
        int iamp, ramp, di, dr;
        ibase = SAMPLE_W'($urandom_range(model_thresh, SMAX));
        rbase = SAMPLE_W'($urandom_range(0, SMAX));
        iamp = $urandom_range(0, 4000);
        ramp = $urandom_range(0, 4000);
        for (int i = 0; i < n; i++) begin
            di = $urandom_range(0, iamp);
            dr = $urandom_range(0, ramp);
            ir = (int'(ibase) + di > int'(SMAX)) ? SMAX : SAMPLE_W'(int'(ibase) + di);
            red = (int'(rbase) + dr > int'(SMAX)) ? SMAX : SAMPLE_W'(int'(rbase) + dr);
            if ($urandom_range(0, 19) == 0) ir = SAMPLE_W'($urandom);
            if ($urandom_range(0, 29) == 0) red = SAMPLE_W'($urandom);
            send_pair(ir, red, use_gaps);
        end
    endtask

    // result receiver with random stalls
    initial begin
        spo2_result_t e;
        int rx_wait;
        rx_wait = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                n_results++;
                if (m_estimate_valid) n_valid_est++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction");
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_contact !== e.contact) begin
                        $error("contact exp %0d act %0d", e.contact, m_contact);
                        errors++;
                    end
                    if (m_estimate_valid !== e.estimate_valid) begin
                        $error("estimate_valid exp %0d act %0d",
                               e.estimate_valid, m_estimate_valid);
                        errors++;
                    end
                    if (m_saturation !== e.saturation) begin
                        $error("saturation exp %0d act %0d",
                               e.saturation, m_saturation);
                        errors++;
                    end
                end
                m_ready <= 1'b0;
                rx_wait = $urandom_range(0, 15);
            end else if (hold_off) begin
                m_ready <= 1'b0;
            end else if (!m_ready) begin
                if (rx_wait == 0) m_ready <= 1'b1;
                else rx_wait--;
            end
        end
    end

    // watchdog on transactions of any channel
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready) || hold_off)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // receiver hold-off for the pressure phase
    task automatic hold_receiver();
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    endtask

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        spo2_result_t zero_res, contact_only;
        errors = 0; n_results = 0; n_valid_est = 0; hold_off = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0; cfg_data = '0;
        s_valid = 1'b0; s_ir_sample = '0; s_red_sample = '0;
        model_thresh = THRESH_RESET; model_wpos = 0; model_full = 1'b0;
        for (int i = 0; i < WLEN; i++) begin
            model_ir_win[i] = '0;
            model_red_win[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        zero_res = '0;
        contact_only = '0;
        contact_only.contact = 1'b1;
        // directed: threshold edges at reset value, extremes, window not full
        rows.push_back('{18'd0,    SMAX,   1, zero_res});
        rows.push_back('{18'd4999, 18'd7,  1, zero_res});
        rows.push_back('{18'd5000, 18'd0,  1, contact_only});
        rows.push_back('{SMAX,     SMAX,   1, contact_only});
        rows.push_back('{SMAX,     18'd0,  1, contact_only});
        rows.push_back('{18'd5000, SMAX,   1, contact_only});
        foreach (rows[i]) begin
            row = rows[i];
            send_pair(row.ir, row.red, 0, row.check_fixed, row.fixed);
        end
        // more contact pairs with constant ir; the window stays two pairs short of full, no estimate
        for (int i = 0; i < WLEN - 6; i++) send_pair(18'd9000, 18'd100, 0);
        // window with zero red swing: clamps to full scale
        for (int i = 0; i < WLEN; i++) send_pair(i % 2 ? 18'd9000 : 18'd8000, 18'd500, 0);
        send_pair(18'd8000, 18'd500, 0, 1, '{1'b1, 1'b1, SAT_MAX});
        // large red swing drives estimate to zero
        for (int i = 0; i < 8; i++) send_pair(i % 2 ? 18'd9000 : 18'd8999,
                                              i % 2 ? SMAX : 18'd1, 0);
        drain();

        // zero threshold, all-zero samples: zero sums
        write_thresh('0);
        for (int i = 0; i < WLEN + 2; i++) send_pair('0, '0, 0);
        send_pair('0, '0, 0, 1, contact_only);
        drain();
        // maximum threshold: only full-scale ir passes
        write_thresh(SMAX);
        send_pair(SMAX - 1'b1, SMAX, 0, 1, zero_res);
        send_pair(SMAX, 18'd3, 0);
        drain();

        // random phases under several threshold settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_thresh(THRESH_RESET);
                1: write_thresh('0);
                7: write_thresh(SMAX - 18'd3000);
                default: write_thresh(SAMPLE_W'($urandom_range(0, 200000)));
            endcase
            if (ph == 2) fork
                hold_receiver();
                send_pulse_run(40, 0);
            join
            for (int k = 0; k < N_RANDOM / 8 / 25; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    // noise
                    for (int j = 0; j < 10; j++)
                        send_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                                  $urandom_range(0, 1));
                end else begin
                    send_pulse_run(25, ph != 4);
                end
            end
            drain();
        end

        $display("covered %0d results, %0d with a valid estimate,", n_results, n_valid_est);
        $display("threshold sweep incl. both extremes, stalls and receiver hold-off");
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: spo2_ratio_window_estimator_unit.f
src/spo2rw_pkg.sv
src/spo2rw_datapath.sv
src/spo2rw_ctrl.sv
src/spo2_ratio_window_estimator_unit.sv
sim/tb_top.sv
